### rtl/shm_pkg.sv
// Package for the SHA-256 message hasher: round constants, initial hash values,
// round and schedule helper functions, and the queue entry type. No dependencies.
`default_nettype none
package shm_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } in_item_t;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

### rtl/shm_stream_if.sv
// Valid/ready channel interfaces for the hasher input and digest output.
// Depends on nothing.
`default_nettype none
interface shm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;
  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface shm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

### rtl/shm_front.sv
// Front end: accepts beats, drops idle items and queues the rest.
// Depends on shm_pkg and shm_stream_if.
`default_nettype none
module shm_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  shm_in_if.sink            in_ch,
  output shm_pkg::in_item_t q_item,
  output logic              q_valid,
  input  wire logic         q_pop
);
  import shm_pkg::*;

  in_item_t           mem_r [QDEPTH];
  logic [QAW-1:0]     wp_r, rp_r;
  logic [QAW:0]       cnt_r;
  logic               push;
  logic               pop;

  assign in_ch.ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign push = in_ch.valid && in_ch.ready && (in_ch.byte_present || in_ch.message_end);
  assign q_valid = (cnt_r != '0);
  assign pop = q_pop && q_valid;
  assign q_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{in_ch.data_byte, in_ch.byte_present, in_ch.message_end};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

### rtl/shm_back.sv
// Back end: byte packing, padding, 64-round compression and digest output.
// Depends on shm_pkg and shm_stream_if.
`default_nettype none
module shm_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire shm_pkg::in_item_t q_item,
  input  wire logic         q_valid,
  output logic              q_pop,
  shm_out_if.source         out_ch
);
  import shm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROUND = 6'b000010,
    S_ADD   = 6'b000100,
    S_PAD   = 6'b001000,
    S_LEN   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t         st_r;
  word_t          h_r [8];
  word_t          w_r [16];
  word_t          v_r [8];
  logic [63:0]    bits_r;
  logic [5:0]     rnd_r;
  logic           fin_r;
  logic           two_r;
  logic           last_r;
  logic [2:0]     oi_r;

  logic [5:0]     pos;
  word_t          wt, t1, t2, wnew;
  logic [3:0]     pw;
  logic [1:0]     pb;

  assign pos = bits_r[8:3];
  assign pw = pos[5:2];
  assign pb = pos[1:0];
  assign wt = w_r[0];
  assign wnew = w_r[0] + sig0(w_r[1]) + w_r[9] + sig1(w_r[14]);
  assign t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
              + round_k(rnd_r) + wt;
  assign t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_ch.valid = (st_r == S_EMIT);
  assign out_ch.digest_word = h_r[oi_r];
  assign out_ch.word_index = oi_r;
  assign out_ch.last_word = (oi_r == 3'd7);

  function automatic word_t put(input word_t w, input logic [1:0] b, input logic [7:0] d);
    word_t r;
    case (b)
      2'd0: r = {d, 24'h0};
      2'd1: r = {w[31:24], d, 16'h0};
      2'd2: r = {w[31:16], d, 8'h0};
      default: r = {w[31:8], d};
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      bits_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      two_r <= 1'b0;
      last_r <= 1'b0;
      oi_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            fin_r <= q_item.message_end;
            if (q_item.byte_present) begin
              w_r[pw] <= put(w_r[pw], pb, q_item.data_byte);
              bits_r <= bits_r + 64'd8;
              if (pos == 6'd63) begin
                st_r <= S_ROUND;
                rnd_r <= '0;
                for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
              end else if (q_item.message_end) begin
                st_r <= S_PAD;
              end
            end else begin
              st_r <= S_PAD;
            end
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) st_r <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (last_r) begin
            last_r <= 1'b0;
            fin_r <= 1'b0;
            oi_r <= '0;
            st_r <= S_EMIT;
          end else if (!fin_r) begin
            st_r <= S_IDLE;
          end else if (two_r) begin
            two_r <= 1'b0;
            for (int i = 0; i < 16; i++) w_r[i] <= '0;
            st_r <= S_LEN;
          end else begin
            st_r <= S_PAD;
          end
        end
        S_PAD: begin
          w_r[pw] <= put(w_r[pw], pb, 8'h80);
          for (int i = 0; i < 16; i++) if (4'(i) > pw) w_r[i] <= '0;
          if (pos >= 6'd56) two_r <= 1'b1;
          st_r <= S_LEN;
        end
        S_LEN: begin
          if (!two_r) begin
            w_r[14] <= bits_r[63:32];
            w_r[15] <= bits_r[31:0];
            last_r <= 1'b1;
          end
          st_r <= S_ROUND;
          rnd_r <= '0;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            oi_r <= oi_r + 3'd1;
            if (oi_r == 3'd7) begin
              st_r <= S_IDLE;
              bits_r <= '0;
              for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/sha256_message_hasher_unit.sv
// SHA-256 message hasher: accepts message bytes one per beat, pads on message end
// and returns the eight digest words H0..H7. A 4-entry queue separates the byte
// front end from the round engine, which runs one round per cycle; message end
// adds one or two blocks plus eight output beats.
// Depends on shm_pkg, shm_stream_if, shm_front and shm_back.
`default_nettype none
module sha256_message_hasher_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  shm_in_if.sink    in_ch,
  shm_out_if.source out_ch
);
  import shm_pkg::*;

  in_item_t q_item;
  logic     q_valid;
  logic     q_pop;

  shm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
  );

  shm_back u_back (
    .clk(clk), .rst_n(rst_n), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
    .out_ch(out_ch)
  );
endmodule
`default_nettype wire

### sim/sha256_message_hasher_unit_tb.sv
// Self-checking bench for the SHA-256 message hasher: drives message bytes in bursts,
// stalls the digest side, and compares every digest word with a built-in predictor.
// Depends on shm_pkg, shm_stream_if and sha256_message_hasher_unit.
`default_nettype none
module sha256_message_hasher_unit_tb;
  import shm_pkg::*;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  typedef struct {
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        message_end;
    logic        typed;
    logic [31:0] h0;
  } stim_row_t;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic clk;
  logic rst_n;
  shm_in_if in_ch ();
  shm_out_if out_ch ();

  sha256_message_hasher_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  word_t        hash_state[8];
  word_t        msg_words[16];
  logic [63:0]  msg_bits;
  digest_beat_t digest_q[$];
  logic [32:0]  typed_h0_q[$];
  int unsigned  errors;
  int unsigned  idle_cycles;
  bit           stim_done;
  bit           hold_off;

  function automatic word_t ror(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hasher_restart();
    hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    foreach (msg_words[i]) msg_words[i] = '0;
    msg_bits = '0;
  endtask

  task automatic hasher_compress();
    word_t w[64];
    word_t v[8];
    word_t t1;
    word_t t2;
    for (int i = 0; i < 16; i++) w[i] = msg_words[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(6'(i)) + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic hasher_put(int unsigned pos, logic [7:0] b);
    if (pos[1:0] == 2'd0) msg_words[pos >> 2] = {b, 24'h0};
    else msg_words[pos >> 2][(3 - pos[1:0]) * 8 +: 8] = b;
  endtask

  task automatic hasher_absorb(logic [7:0] b, logic present, logic fin);
    int unsigned pos;
    digest_beat_t d;
    if (present) begin
      pos = msg_bits[8:3];
      hasher_put(pos, b);
      msg_bits += 64'd8;
      if (pos == 63) hasher_compress();
    end
    if (fin) begin
      pos = msg_bits[8:3];
      hasher_put(pos, 8'h80);
      for (int i = (pos >> 2) + 1; i < 16; i++) msg_words[i] = '0;
      if (pos >= 56) begin
        hasher_compress();
        foreach (msg_words[i]) msg_words[i] = '0;
      end
      msg_words[14] = msg_bits[63:32];
      msg_words[15] = msg_bits[31:0];
      hasher_compress();
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_state[i];
        d.word_index = 3'(i);
        d.last_word = (i == 7);
        digest_q.push_back(d);
      end
      hasher_restart();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic send_beat(logic [7:0] b, logic present, logic fin);
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.byte_present <= present;
    in_ch.message_end <= fin;
    do @(posedge clk); while (!in_ch.ready);
    hasher_absorb(b, present, fin);
  endtask

  int unsigned burst_left;

  task automatic offer(logic [7:0] b, logic present, logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_beat(b, present, fin);
  endtask

  task automatic send_message(int unsigned len, int unsigned mode);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) offer(8'($urandom), 1'b0, 1'b0);
      offer(mode == 1 ? 8'hff : mode == 2 ? 8'h00 : 8'($urandom), 1'b1,
            (i == len - 1) && $urandom_range(0, 1));
    end
    if (digest_q.size() == 0 || msg_bits != 0) offer(8'($urandom), 1'b0, 1'b1);
  endtask

  stim_row_t directed[] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},
    '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442}
  };

  initial begin
    int unsigned sent;
    errors = 0;
    stim_done = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_present = 1'b0;
    in_ch.message_end = 1'b0;
    hasher_restart();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      if (directed[i].message_end) typed_h0_q.push_back({directed[i].typed, directed[i].h0});
      send_beat(directed[i].data_byte, directed[i].byte_present, directed[i].message_end);
    end
    send_message(55, 0);
    send_message(56, 0);
    send_message(64, 1);
    send_message(20, 2);
    sent = 0;
    while (sent < 140) begin
      automatic int unsigned len = $urandom_range(0, 9) == 0 ? $urandom_range(60, 70)
                                                            : $urandom_range(0, 20);
      send_message(len, 0);
      sent += len + 1;
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    hold_off = 1'b0;
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  int unsigned stall_phase;
  always @(posedge clk) begin
    if (!rst_n) stall_phase <= 0;
    else stall_phase <= stall_phase + 1;
    out_ch.ready <= !hold_off && (stall_phase[8] || ($urandom_range(0, 3) != 0));
  end

  always @(posedge clk) begin
    digest_beat_t want;
    logic [32:0]  known;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected word", out_ch.digest_word, '0);
      end else begin
        want = digest_q.pop_front();
        if (want.word_index == 3'd0 && typed_h0_q.size() != 0) begin
          known = typed_h0_q.pop_front();
          if (known[32] && out_ch.digest_word != known[31:0])
            report_mismatch("known H0", out_ch.digest_word, known[31:0]);
        end
        if (out_ch.digest_word != want.digest_word)
          report_mismatch("digest_word", out_ch.digest_word, want.digest_word);
        if (out_ch.word_index != want.word_index)
          report_mismatch("word_index", out_ch.word_index, want.word_index);
        if (out_ch.last_word != want.last_word)
          report_mismatch("last_word", out_ch.last_word, want.last_word);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (rst_n);
    fork
      begin
        wait (stim_done && digest_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && typed_h0_q.size() == 0) begin
          $display("*** PASSED ***");
        end else begin
          $display("*** FAILED ***");
        end
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("timeout waiting for a beat");
        $display("*** FAILED ***");
      end
    join_any
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/shm_pkg.sv
rtl/shm_stream_if.sv
rtl/shm_front.sv
rtl/shm_back.sv
rtl/sha256_message_hasher_unit.sv
sim/sha256_message_hasher_unit_tb.sv
